>>> sv/swmd_pkg.sv
package swmd_pkg;

	localparam int STACK_DEPTH_DEF = 64;
	localparam int DATA_W          = 32;
	localparam int REQ_W           = 2;
	localparam int ERR_W           = 2;
	localparam int COUNT_OUT_W     = 7;

	localparam logic [REQ_W-1:0] REQ_PUSH    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_POP     = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DEL_MID = 2'd2;
	localparam logic [REQ_W-1:0] REQ_PEEK    = 2'd3;

	localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
	localparam logic [ERR_W-1:0] ERR_UNDER = 2'd1;
	localparam logic [ERR_W-1:0] ERR_OVER  = 2'd2;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic push_ok;
		logic del_ok;
	} cell_ctl_t;

endpackage

>>> sv/swmd_cell.sv
module swmd_cell #(
	parameter int CW  = 7,
	parameter int IDX = 0
) (
	input  logic                              clk,
	input  swmd_pkg::cell_ctl_t               ctl,
	input  logic [CW-1:0]                     count,
	input  logic [CW-1:0]                     top_idx,
	input  logic [CW-1:0]                     mid_idx,
	input  logic signed [swmd_pkg::DATA_W-1:0] push_value,
	input  logic signed [swmd_pkg::DATA_W-1:0] above,
	output logic signed [swmd_pkg::DATA_W-1:0] word,
	output logic [swmd_pkg::DATA_W-1:0]        top_part,
	output logic [swmd_pkg::DATA_W-1:0]        mid_part
);
	import swmd_pkg::*;

	localparam logic [CW-1:0] IDX_C  = CW'(IDX);
	localparam logic [CW-1:0] IDX_P1 = CW'(IDX + 1);

	logic signed [DATA_W-1:0] word_q;

	// push writes the slot at count; delete shifts cells in [mid, count-2] down
	always_ff @(posedge clk) begin
		if (ctl.push_ok && (count == IDX_C)) begin
			word_q <= push_value;
		end else if (ctl.del_ok && (IDX_C >= mid_idx) && (IDX_P1 < count)) begin
			word_q <= above;
		end
	end

	assign word     = word_q;
	assign top_part = (top_idx == IDX_C) ? word_q : '0;
	assign mid_part = (mid_idx == IDX_C) ? word_q : '0;

endmodule

>>> sv/stack_with_middle_delete_top.sv
// Channel  | Ports                                   | Handshake
// request  | req_type, push_value                    | start && !busy
// result   | removed_value, top_value, middle_value, | done, one cycle
//          | entry_count, is_empty, error_code       |
//
// Each request runs through three steps: accept, cell update, read of top and middle.
// done pulses in the cycle after the read; busy is already low then, so a new
// request can be accepted while done is high. The one-hot read networks for top
// and middle are shared between the removal read and the result read.
// Reset clears the count and the sequencer; cell contents stay unknown until
// pushed. The receiver cannot stall: results are valid only while done is high.
module stack_with_middle_delete_top #(
	parameter int STACK_DEPTH = swmd_pkg::STACK_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [swmd_pkg::REQ_W-1:0]          req_type,
	input  logic signed [swmd_pkg::DATA_W-1:0]  push_value,
	output logic                                done,
	output logic signed [swmd_pkg::DATA_W-1:0]  removed_value,
	output logic signed [swmd_pkg::DATA_W-1:0]  top_value,
	output logic signed [swmd_pkg::DATA_W-1:0]  middle_value,
	output logic [swmd_pkg::COUNT_OUT_W-1:0]    entry_count,
	output logic                                is_empty,
	output logic [swmd_pkg::ERR_W-1:0]          error_code
);
	import swmd_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] FULL_C = CW'(STACK_DEPTH);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;

	logic [1:0]               state_q;
	logic [REQ_W-1:0]         req_q;
	logic signed [DATA_W-1:0] val_q;
	logic [CW-1:0]            count_q;
	logic                     done_q;
	logic signed [DATA_W-1:0] removed_q;
	logic signed [DATA_W-1:0] top_q;
	logic signed [DATA_W-1:0] mid_q;
	logic [COUNT_OUT_W-1:0]   count_out_q;
	logic                     empty_q;
	logic [ERR_W-1:0]         err_q;

	logic [CW-1:0]            top_idx;
	logic [CW-1:0]            mid_idx;
	logic                     is_full;
	logic                     is_zero;
	cell_ctl_t                ctl;
	logic signed [DATA_W-1:0] words [STACK_DEPTH];
	logic [DATA_W-1:0]        top_parts [STACK_DEPTH];
	logic [DATA_W-1:0]        mid_parts [STACK_DEPTH];
	logic [DATA_W-1:0]        top_rd;
	logic [DATA_W-1:0]        mid_rd;

	assign top_idx = count_q - CW'(1);
	assign mid_idx = count_q >> 1;
	assign is_full = (count_q == FULL_C);
	assign is_zero = (count_q == '0);

	always_comb begin
		ctl.push_ok = (state_q == ST_EXEC) && (req_q == REQ_PUSH) && !is_full;
		ctl.del_ok  = (state_q == ST_EXEC) && (req_q == REQ_DEL_MID) && !is_zero;
	end

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic signed [DATA_W-1:0] above;
		if (i == STACK_DEPTH - 1) begin : g_last
			assign above = words[i];
		end else begin : g_mid
			assign above = words[i+1];
		end
		swmd_cell #(.CW(CW), .IDX(i)) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.count      (count_q),
			.top_idx    (top_idx),
			.mid_idx    (mid_idx),
			.push_value (val_q),
			.above      (above),
			.word       (words[i]),
			.top_part   (top_parts[i]),
			.mid_part   (mid_parts[i])
		);
	end

	always_comb begin
		top_rd = '0;
		mid_rd = '0;
		for (int i = 0; i < STACK_DEPTH; i++) begin
			top_rd = top_rd | top_parts[i];
			mid_rd = mid_rd | mid_parts[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_READ;
					unique case (req_q) inside
						REQ_PUSH: begin
							if (!is_full) begin
								count_q <= count_q + CW'(1);
							end
						end
						REQ_POP, REQ_DEL_MID: begin
							if (!is_zero) begin
								count_q <= count_q - CW'(1);
							end
						end
						default: begin
						end
					endcase
				end
				ST_READ: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			req_q <= req_type;
			val_q <= push_value;
		end
		if (state_q == ST_EXEC) begin
			removed_q <= '0;
			err_q     <= ERR_OK;
			unique case (req_q)
				REQ_PUSH: begin
					if (is_full) begin
						err_q <= ERR_OVER;
					end
				end
				REQ_POP: begin
					if (is_zero) begin
						err_q <= ERR_UNDER;
					end else begin
						removed_q <= top_rd;
					end
				end
				REQ_DEL_MID: begin
					if (is_zero) begin
						err_q <= ERR_UNDER;
					end else begin
						removed_q <= mid_rd;
					end
				end
				default: begin
				end
			endcase
		end
		if (state_q == ST_READ) begin
			top_q       <= is_zero ? '0 : top_rd;
			mid_q       <= is_zero ? '0 : mid_rd;
			empty_q     <= is_zero;
			count_out_q <= COUNT_OUT_W'(count_q);
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign removed_value = removed_q;
	assign top_value     = top_q;
	assign middle_value  = mid_q;
	assign entry_count   = count_out_q;
	assign is_empty      = empty_q;
	assign error_code    = err_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_C)
		else $error("stack count above depth");

	a_done_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_READ))
		else $error("done without a read cycle");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ST_EXEC))
		else $error("accepted transaction did not execute");

	a_over_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (error_code == ERR_OVER)) |-> is_full)
		else $error("overflow reported while not full");

	a_under_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (error_code == ERR_UNDER)) |-> (is_zero && is_empty))
		else $error("underflow reported while not empty");

endmodule
